// ===== sv/sorted_top_k_insert_table_top_defines.svh =====
// Assertion macros for the checker file of the sorted top-k table
`ifndef SORTED_TOP_K_INSERT_TABLE_TOP_DEFINES_SVH
`define SORTED_TOP_K_INSERT_TABLE_TOP_DEFINES_SVH

// Clocked assertion, muted while reset is held
`define STKT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset
`define STKT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/stkt_pkg.sv =====
// Package: widths, codes, cell control struct and sort-key helper for the top-k table
`default_nettype none
package stkt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int SCORE_W     = 32;
  localparam int NAME_W      = 24;
  localparam int ACT_W       = 5;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;

  // input tdata layout
  localparam int IN_SCORE_LSB = 0;
  localparam int IN_NAME_LSB  = IN_SCORE_LSB + SCORE_W;
  localparam int IN_IDX_LSB   = IN_NAME_LSB + NAME_W;

  // output tdata layout
  localparam int OUT_PLACED_BIT = 0;
  localparam int OUT_POS_LSB    = 1;
  localparam int OUT_SCORE_LSB  = OUT_POS_LSB + IDX_W;
  localparam int OUT_NAME_LSB   = OUT_SCORE_LSB + SCORE_W;
  localparam int OUT_USED_W     = OUT_NAME_LSB + NAME_W;

  localparam logic [NAME_W-1:0]  EMPTY_NAME   = 24'h414141;
  localparam logic [ACT_W-1:0]   ACTIVE_RESET = 5'd10;

  localparam logic [CFG_ADDR_W-1:0] REG_ORDER_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE     = 1'b1;

  localparam logic MODE_DESC = 1'b0;
  localparam logic MODE_ASC  = 1'b1;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic               ins;
    logic               asc;
    logic [ACT_W-1:0]   n;
    logic [SCORE_W-1:0] score;
    logic [NAME_W-1:0]  name;
  } cell_ctrl_t;

  // ascending key: zero wraps to the top so empty slots sort last
  function automatic logic [SCORE_W-1:0] asc_key(input logic [SCORE_W-1:0] s);
    asc_key = s - SCORE_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== sv/stkt_cell.sv =====
// One table slot: compares the new score, takes the new pair or its left neighbour's
`default_nettype none
module stkt_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [stkt_pkg::ACT_W-1:0]  slot_idx,
  input  wire stkt_pkg::cell_ctrl_t        ctrl,
  input  wire logic                        hit_in,
  input  wire logic [stkt_pkg::SCORE_W-1:0] left_score,
  input  wire logic [stkt_pkg::NAME_W-1:0]  left_name,
  output logic                             hit_out,
  output logic                             first_hit,
  output logic [stkt_pkg::SCORE_W-1:0]     score_q,
  output logic [stkt_pkg::NAME_W-1:0]      name_q
);
  import stkt_pkg::*;

  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [NAME_W-1:0]  name_r, name_nxt;
  logic               active;
  logic               hit_self;

  always_comb begin
    active = slot_idx < ctrl.n;
    if (ctrl.asc == MODE_ASC) begin
      hit_self = active && (asc_key(ctrl.score) <= asc_key(score_r));
    end else begin
      hit_self = active && (ctrl.score > score_r);
    end
    first_hit = hit_self && !hit_in;
    hit_out   = hit_in || hit_self;
  end

  always_comb begin
    score_nxt = score_r;
    name_nxt  = name_r;
    if (ctrl.ins && active) begin
      priority if (first_hit) begin
        score_nxt = ctrl.score;
        name_nxt  = ctrl.name;
      end else if (hit_in) begin
        // shift down behind the insertion slot
        score_nxt = left_score;
        name_nxt  = left_name;
      end else begin
        // hold above the insertion slot
        score_nxt = score_r;
        name_nxt  = name_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      name_r  <= EMPTY_NAME;
    end else begin
      score_r <= score_nxt;
      name_r  <= name_nxt;
    end
  end

  assign score_q = score_r;
  assign name_q  = name_r;

endmodule
`default_nettype wire

// ===== sv/sorted_top_k_insert_table_top.sv =====
// Top level: sorted top-k table built as a row of slot cells with a registered result
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata score,name_tag,read_index; tuser req_type
//  out_    | out | out_tvalid/out_tready | tdata placed,position,entry_score,entry_name
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_addr register index, cfg_data value
//
// One item per cycle while in_tready is high; its result appears in the output register on the next cycle.
// The rank search ripples a hit flag through all slot cells, which sets the clock path.
// in_tready drops only while a result waits and out_tready is low.
// Synchronous active-low reset loads the empty table at once; no clearing pass.
// cfg_ready is always high.
`default_nettype none
module sorted_top_k_insert_table_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [31:0] score, [55:32] name_tag, [59:56] read_index, [63:60] zero
  input  wire logic [stkt_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] req_type
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] placed, [4:1] position, [36:5] entry_score, [60:37] entry_name, [63:61] zero
  output logic [stkt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stkt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [stkt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stkt_pkg::*;

  logic                  order_r;
  logic [ACT_W-1:0]      active_r;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  accept;
  logic [ACT_W-1:0]      n_used;
  cell_ctrl_t            ctrl;
  logic [TABLE_DEPTH:0]  hit_c;
  logic [TABLE_DEPTH-1:0] first_c;
  logic [SCORE_W-1:0]    score_q [TABLE_DEPTH];
  logic [NAME_W-1:0]     name_q  [TABLE_DEPTH];
  logic [IDX_W-1:0]      pos_new;
  logic                  placed;
  logic [IDX_W-1:0]      rd_idx;
  logic [SCORE_W-1:0]    rd_score;
  logic [NAME_W-1:0]     rd_name;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (active_r > ACT_W'(TABLE_DEPTH)) begin
      n_used = ACT_W'(TABLE_DEPTH);
    end else begin
      n_used = active_r;
    end
    ctrl.ins   = accept && (in_tuser == REQ_INSERT);
    ctrl.asc   = order_r;
    ctrl.n     = n_used;
    ctrl.score = in_tdata[IN_SCORE_LSB +: SCORE_W];
    ctrl.name  = in_tdata[IN_NAME_LSB +: NAME_W];
  end

  assign hit_c[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      stkt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_idx   (ACT_W'(i)),
        .ctrl       (ctrl),
        .hit_in     (hit_c[i]),
        .left_score (ctrl.score),
        .left_name  (ctrl.name),
        .hit_out    (hit_c[i+1]),
        .first_hit  (first_c[i]),
        .score_q    (score_q[i]),
        .name_q     (name_q[i])
      );
    end else begin : g_body
      stkt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_idx   (ACT_W'(i)),
        .ctrl       (ctrl),
        .hit_in     (hit_c[i]),
        .left_score (score_q[i-1]),
        .left_name  (name_q[i-1]),
        .hit_out    (hit_c[i+1]),
        .first_hit  (first_c[i]),
        .score_q    (score_q[i]),
        .name_q     (name_q[i])
      );
    end
  end

  // encode the one-hot insertion slot
  always_comb begin
    pos_new = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_c[i]) begin
        pos_new = pos_new | IDX_W'(i);
      end
    end
  end

  always_comb begin
    rd_idx   = in_tdata[IN_IDX_LSB +: IDX_W];
    rd_score = '0;
    rd_name  = '0;
    if (32'(rd_idx) < TABLE_DEPTH) begin
      rd_score = score_q[rd_idx];
      rd_name  = name_q[rd_idx];
    end
  end

  always_comb begin
    placed        = ctrl.ins && hit_c[TABLE_DEPTH];
    last_nxt      = placed ? pos_new : last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_PLACED_BIT]        = placed;
      out_data_nxt[OUT_POS_LSB +: IDX_W]  = last_nxt;
      if (in_tuser == REQ_READ) begin
        out_data_nxt[OUT_SCORE_LSB +: SCORE_W] = rd_score;
        out_data_nxt[OUT_NAME_LSB +: NAME_W]   = rd_name;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= MODE_DESC;
      active_r    <= ACTIVE_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          REG_ORDER_MODE: order_r  <= cfg_data[0];
          REG_ACTIVE:     active_r <= cfg_data[ACT_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== sv/stkt_checker.sv =====
// Port-level checker for the sorted top-k table, bound to the top level
`default_nettype none
`include "sorted_top_k_insert_table_top_defines.svh"
module stkt_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [stkt_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import stkt_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  `STKT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `STKT_ASSERT(a_result_follows, clk, rst_n, in_xfer |=> out_tvalid, "accepted item gave no result")
  `STKT_ASSERT(a_read_not_placed, clk, rst_n, in_xfer && (in_tuser == REQ_READ) |=> !out_tdata[OUT_PLACED_BIT], "read reported a placement")
  `STKT_ASSERT(a_insert_no_entry, clk, rst_n, in_xfer && (in_tuser == REQ_INSERT) |=> out_tdata[OUT_USED_W-1:OUT_SCORE_LSB] == '0, "insert returned entry data")
  `STKT_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid straight after reset")

endmodule

bind sorted_top_k_insert_table_top stkt_checker u_stkt_checker (.*);
`default_nettype wire
